### design/pxs_pkg.sv
// ============================================================================
// Proximity smoothstep package
// Shared widths, register indexes, reset values and payload types.
// ============================================================================
package pxs_pkg;

    localparam int COORD_W     = 32;
    localparam int DIST_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int PROX_W      = 17;
    localparam int MUL_W       = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DISTANCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DISTANCE = 2'd1;

    localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 32'd0;
    localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 32'd65536;

    // Proximity of one in Q1.16, and the constant 3.0 in Q2.16 for smoothstep.
    localparam logic [PROX_W-1:0]   PROX_ONE     = 17'd65536;
    localparam logic [FRAC_W+1:0]   SMOOTH_THREE = 18'd196608;

    typedef struct packed {
        logic signed [COORD_W-1:0] ref_x;
        logic signed [COORD_W-1:0] ref_y;
        logic signed [COORD_W-1:0] ref_z;
        logic signed [COORD_W-1:0] cur_x;
        logic signed [COORD_W-1:0] cur_y;
        logic signed [COORD_W-1:0] cur_z;
    } pxs_item_t;

    typedef struct packed {
        logic [PROX_W-1:0] proximity;
        logic              out_of_range;
        logic              proximity_changed;
        logic              range_changed;
    } pxs_result_t;

endpackage

### design/proximity_smoothstep.sv
// ============================================================================
// Proximity smoothstep
// Smoothed proximity of two 3D points against a configured distance range.
// ============================================================================
// One item at a time: after a transfer, item_stall stays high until the result
// is loaded into the output register; longer when the distance falls strictly
// inside the configured range, and longer while a stalled earlier result holds
// the output register. The 32-step square root dominates, then the 16-step divide;
// the squares and the smoothstep products share one registered 32 x 32
// multiplier. The result register lets the next item start while a result
// still waits. Configuration writes are always taken. The range registers are
// read partway through an item, so writes belong in gaps with no item in
// flight.
module proximity_smoothstep
    import pxs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  pxs_item_t               item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output pxs_result_t             result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [DIST_W-1:0]       cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQZ,
        S_SQACC,
        S_SQRT,
        S_CLASS,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_ROUND,
        S_DONE
    } state_t;

    localparam logic [2*MUL_W-1:0] ROUND_HALF = 64'h0000_0000_8000_0000;
    localparam logic [DIST_W:0]    DIST_SAT   = {1'b1, {DIST_W{1'b0}}};

    state_t              state_reg;
    state_t              state_next;
    pxs_result_t         result_reg;
    logic                result_valid_reg;
    logic [PROX_W-1:0]   last_prox_reg;
    logic                last_oor_reg;
    logic [DIST_W-1:0]   min_reg;
    logic [DIST_W-1:0]   max_reg;

    logic [DIST_W-1:0]   dx_reg;
    logic [DIST_W-1:0]   dy_reg;
    logic [DIST_W-1:0]   dz_reg;
    logic [2*DIST_W+1:0] acc_reg;
    logic                sat_reg;
    logic [PROX_W-1:0]   prox_reg;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*MUL_W-1:0]  product;
    logic [2*DIST_W+1:0] sq_sum;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [DIST_W-1:0]   root;
    logic                div_start;
    logic                div_done;
    logic [FRAC_W-1:0]   quotient;
    logic [2*MUL_W-1:0]  round_sum;

    logic [DIST_W:0]     distance;
    logic                class_direct;
    logic [PROX_W-1:0]   class_prox;
    logic [DIST_W-1:0]   div_numer;
    logic [DIST_W-1:0]   div_denom;
    logic                load_result;
    logic                result_oor;

    function automatic logic [DIST_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic [COORD_W:0] d;
        logic [COORD_W:0] mag;
        d   = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        mag = d[COORD_W] ? (~d + 1'b1) : d;
        return mag[DIST_W-1:0];
    endfunction

    assign item_stall   = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            S_SQY:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            S_SQZ:
            begin
                mul_a = dz_reg;
                mul_b = dz_reg;
            end
            S_MUL1:
            begin
                mul_a = {{(MUL_W-FRAC_W){1'b0}}, quotient};
                mul_b = {{(MUL_W-FRAC_W){1'b0}}, quotient};
            end
            S_MUL2:
            begin
                mul_a = product[MUL_W-1:0];
                mul_b = {{(MUL_W-FRAC_W-2){1'b0}},
                         SMOOTH_THREE - {1'b0, quotient, 1'b0}};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pxs_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    assign sq_sum     = acc_reg + {2'b00, product};
    assign sqrt_start = (state_reg == S_SQACC);

    pxs_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_sum[2*DIST_W-1:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    // Place the distance against the range. Inside the range the divider
    // forms the fraction toward the far end; otherwise the result is direct.
    always_comb
    begin
        distance     = sat_reg ? DIST_SAT : {1'b0, root};
        class_direct = 1'b1;
        class_prox   = '0;
        div_numer    = max_reg - distance[DIST_W-1:0];
        div_denom    = max_reg - min_reg;
        if (max_reg == min_reg)
        begin
            class_prox = (distance <= {1'b0, min_reg}) ? PROX_ONE : '0;
        end
        else if (max_reg > min_reg)
        begin
            if (distance <= {1'b0, min_reg})
                class_prox = PROX_ONE;
            else if (distance >= {1'b0, max_reg})
                class_prox = '0;
            else
                class_direct = 1'b0;
        end
        else
        begin
            div_numer = distance[DIST_W-1:0] - max_reg;
            div_denom = min_reg - max_reg;
            if (distance >= {1'b0, min_reg})
                class_prox = PROX_ONE;
            else if (distance <= {1'b0, max_reg})
                class_prox = '0;
            else
                class_direct = 1'b0;
        end
    end

    assign div_start = (state_reg == S_CLASS) && !class_direct;

    pxs_divu u_divu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .done     (div_done),
        .quotient (quotient)
    );

    assign round_sum   = product + ROUND_HALF;
    assign load_result = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);
    assign result_oor  = (prox_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (item_valid) state_next = S_SQX;
            S_SQX:   state_next = S_SQY;
            S_SQY:   state_next = S_SQZ;
            S_SQZ:   state_next = S_SQACC;
            S_SQACC: state_next = S_SQRT;
            S_SQRT:  if (sqrt_done) state_next = S_CLASS;
            S_CLASS: state_next = class_direct ? S_DONE : S_DIV;
            S_DIV:   if (div_done) state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_ROUND;
            S_ROUND: state_next = S_DONE;
            S_DONE:  if (load_result) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            last_prox_reg    <= '0;
            last_oor_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_result)
            begin
                result_valid_reg             <= 1'b1;
                result_reg.proximity         <= prox_reg;
                result_reg.out_of_range      <= result_oor;
                result_reg.proximity_changed <= (prox_reg != last_prox_reg);
                result_reg.range_changed     <= (result_oor != last_oor_reg);
                last_prox_reg                <= prox_reg;
                last_oor_reg                 <= result_oor;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_DISTANCE_RST;
            max_reg <= MAX_DISTANCE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_DISTANCE: min_reg <= cfg_data;
                CFG_MAX_DISTANCE: max_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Datapath registers. A sum of squares at or above 2^64 saturates the
    // distance beyond any configurable value.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dx_reg <= abs_diff(item.ref_x, item.cur_x);
                dy_reg <= abs_diff(item.ref_y, item.cur_y);
                dz_reg <= abs_diff(item.ref_z, item.cur_z);
            end
            S_SQY:   acc_reg <= {2'b00, product};
            S_SQZ:   acc_reg <= sq_sum;
            S_SQACC: sat_reg <= (sq_sum[2*DIST_W+1:2*DIST_W] != 2'b00);
            S_CLASS: prox_reg <= class_prox;
            S_ROUND: prox_reg <= round_sum[2*FRAC_W +: PROX_W];
            default: ;
        endcase
    end

endmodule

### design/pxs_mul.sv
// ============================================================================
// Shared multiplier
// Unsigned 32 x 32 multiplier with a registered product.
// ============================================================================
module pxs_mul
    import pxs_pkg::*;
(
    input  logic                 clk,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]   product
);

    logic [2*MUL_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= a * b;
    end

    assign product = product_reg;

endmodule

### design/pxs_isqrt.sv
// ============================================================================
// Iterative square root
// Floor square root of a 64-bit value, one root bit per cycle.
// ============================================================================
module pxs_isqrt
    import pxs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2*DIST_W-1:0]   radicand,
    output logic                  done,
    output logic [DIST_W-1:0]     root
);

    localparam int CNT_W = $clog2(DIST_W);

    logic [2*DIST_W-1:0] rad_reg;
    logic [DIST_W:0]     rem_reg;
    logic [DIST_W-1:0]   root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DIST_W+2:0]   rem_shift;
    logic [DIST_W+2:0]   trial;
    logic [DIST_W+2:0]   diff;
    logic                fits;

    // Bring down the next two radicand bits and try the root bit at one.
    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[2*DIST_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_shift - trial;
        fits      = rem_shift >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIST_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*DIST_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[DIST_W:0] : rem_shift[DIST_W:0];
            root_reg <= {root_reg[DIST_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### design/pxs_divu.sv
// ============================================================================
// Iterative fraction divider
// Restoring divide of a numerator below the denominator, giving a Q0.16
// quotient one bit per cycle.
// ============================================================================
module pxs_divu
    import pxs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIST_W-1:0]    numer,
    input  logic [DIST_W-1:0]    denom,
    output logic                 done,
    output logic [FRAC_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(FRAC_W);

    logic [DIST_W-1:0] rem_reg;
    logic [DIST_W-1:0] den_reg;
    logic [FRAC_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIST_W:0]   rem_shift;
    logic [DIST_W:0]   diff;
    logic              fits;

    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        diff      = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The numerator is always below the denominator, so the remainder
    // stays within the denominator's width.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= numer;
            den_reg <= denom;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIST_W-1:0] : rem_shift[DIST_W-1:0];
            quo_reg <= {quo_reg[FRAC_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/pxs_checker.sv
// ============================================================================
// Proximity smoothstep checker
// Port-level assertions for the proximity smoothstep block, bound to the
// top level.
// ============================================================================
module pxs_props
    import pxs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  logic                    item_stall,
    input  logic                    result_valid,
    input  logic                    result_stall,
    input  pxs_result_t             result
);

    // A stalled result must hold until its transfer.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // The range flag is set exactly when proximity is zero.
    a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.out_of_range == (result.proximity == '0)))
        else $error("out_of_range disagrees with proximity");

    // Proximity never exceeds one.
    a_prox_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.proximity <= PROX_ONE))
        else $error("proximity above one");

    // The block works on one item at a time.
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second item taken while busy");

endmodule

bind proximity_smoothstep pxs_props u_pxs_props (.*);

### dv/pxs_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Proximity smoothstep checker
// Watches the item, result and register channels. It predicts the result of
// every accepted item from its own copy of the range registers and of the
// stored proximity state, and compares each result with the oldest one waiting.
// ============================================================================
module pxs_checker
    import pxs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  logic                    item_stall,
    input  pxs_item_t               item,
    input  logic                    result_valid,
    input  logic                    result_stall,
    input  pxs_result_t             result,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [DIST_W-1:0]       cfg_data,
    output int                      failures,
    output int                      pending
);

    localparam int PRINT_LIMIT = 100;

    logic [DIST_W-1:0]  min_dist;
    logic [DIST_W-1:0]  max_dist;
    logic [PROX_W-1:0]  last_prox;
    logic               last_oor;
    pxs_result_t        expected_q[$];

    // Fields print as proximity/out_of_range/proximity_changed/range_changed.
    task automatic report_mismatch(input string what, input pxs_result_t got,
                                   input pxs_result_t want);
        if (failures < PRINT_LIMIT)
            $display("pxs_checker: %s at %0t: got %0d/%0b/%0b/%0b want %0d/%0b/%0b/%0b",
                     what, $time, got.proximity, got.out_of_range, got.proximity_changed,
                     got.range_changed, want.proximity, want.out_of_range,
                     want.proximity_changed, want.range_changed);
        failures++;
    endtask

    function automatic logic [63:0] axis_gap(input logic signed [COORD_W-1:0] a,
                                             input logic signed [COORD_W-1:0] b);
        longint diff;
        diff = longint'(a) - longint'(b);
        return (diff < 0) ? 64'(-diff) : 64'(diff);
    endfunction

    // Floor square root, one result bit at a time from the top.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Distance in Q16.16. A sum of squares past 64 bits saturates to 2^32.
    function automatic logic [63:0] point_distance(input pxs_item_t it);
        logic [63:0] gx, gy, gz;
        logic [63:0] sx, sy, sz;
        logic [65:0] sum;
        gx = axis_gap(it.ref_x, it.cur_x);
        gy = axis_gap(it.ref_y, it.cur_y);
        gz = axis_gap(it.ref_z, it.cur_z);
        sx = gx * gx;
        sy = gy * gy;
        sz = gz * gz;
        sum = {2'b00, sx} + {2'b00, sy} + {2'b00, sz};
        if (sum[65:64] != 2'b00)
            return 64'h1_0000_0000;
        return floor_sqrt(sum[63:0]);
    endfunction

    // 3t^2 - 2t^3 with t in Q0.16, rounded half up from Q0.48 to Q0.16.
    function automatic logic [PROX_W-1:0] smooth_fraction(input logic [63:0] t);
        logic [63:0] sq;
        logic [63:0] poly;
        sq = t * t;
        poly = sq * (64'(SMOOTH_THREE) - (t << 1));
        poly = (poly + 64'h8000_0000) >> 32;
        return poly[PROX_W-1:0];
    endfunction

    function automatic logic [PROX_W-1:0] proximity_of_distance(input logic [63:0] d);
        logic [63:0] lo, hi, t;
        lo = {32'd0, min_dist};
        hi = {32'd0, max_dist};
        if (hi == lo)
            return (d <= lo) ? PROX_ONE : '0;
        if (hi > lo) begin
            if (d <= lo)
                return PROX_ONE;
            if (d >= hi)
                return '0;
            t = ((hi - d) << 16) / (hi - lo);
        end else begin
            // Inverted range: proximity grows with distance.
            if (d >= lo)
                return PROX_ONE;
            if (d <= hi)
                return '0;
            t = ((d - hi) << 16) / (lo - hi);
        end
        return smooth_fraction(t);
    endfunction

    function automatic pxs_result_t predict_result(input pxs_item_t it);
        pxs_result_t r;
        r.proximity         = proximity_of_distance(point_distance(it));
        r.out_of_range      = (r.proximity == '0);
        r.proximity_changed = (r.proximity != last_prox);
        r.range_changed     = (r.out_of_range != last_oor);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        pxs_result_t want;
        if (!rst_n) begin
            min_dist  = MIN_DISTANCE_RST;
            max_dist  = MAX_DISTANCE_RST;
            last_prox = '0;
            last_oor  = 1'b0;
            expected_q.delete();
            pending   = 0;
        end else begin
            if (result_valid && !result_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected", result, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (result.proximity !== want.proximity
                        || result.out_of_range !== want.out_of_range
                        || result.proximity_changed !== want.proximity_changed
                        || result.range_changed !== want.range_changed)
                        report_mismatch("result mismatch", result, want);
                end
            end
            if (item_valid && !item_stall) begin
                want = predict_result(item);
                last_prox = want.proximity;
                last_oor  = want.out_of_range;
                expected_q.push_back(want);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_DISTANCE: min_dist = cfg_data;
                    CFG_MAX_DISTANCE: max_dist = cfg_data;
                    default: ;
                endcase
            end
            pending = expected_q.size();
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Proximity smoothstep testbench
// Drives point pairs and range register writes into the block under several
// idle and stall patterns, with long output hold-offs, and gives the verdict
// from the failure and pending counts of the checker.
// ============================================================================
module tb;
    import pxs_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 100;
    localparam int NUM_PHASES      = 9;
    localparam int PHASE_ITEMS     = 55;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_stall;
    pxs_item_t              item;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    pxs_result_t            result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DIST_W-1:0]      cfg_data;

    int failures;
    int pending;
    int cycles        = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_taken    = 0;
    int hold_left     = 0;

    // Last written range, used to aim random distances at the interesting region.
    logic [DIST_W-1:0] range_lo;
    logic [DIST_W-1:0] range_hi;

    proximity_smoothstep u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pxs_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Result side: a requested hold-off overrides the random stall pattern.
    always @(negedge clk)
    begin
        if (hold_requests != hold_taken)
        begin
            hold_taken = hold_requests;
            hold_left  = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Places two coordinates a given gap apart, anywhere in the signed range.
    function automatic void place_axis(input logic [63:0] gap,
                                       output logic signed [COORD_W-1:0] a,
                                       output logic signed [COORD_W-1:0] b);
        logic [63:0] g;
        logic [63:0] lowv;
        logic [63:0] highv;
        g     = (gap > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : gap;
        lowv  = {32'd0, $urandom} % (64'h1_0000_0000 - g);
        highv = lowv + g;
        if ($urandom_range(1))
        begin
            a = lowv[31:0] ^ 32'h8000_0000;
            b = highv[31:0] ^ 32'h8000_0000;
        end
        else
        begin
            a = highv[31:0] ^ 32'h8000_0000;
            b = lowv[31:0] ^ 32'h8000_0000;
        end
    endfunction

    function automatic pxs_item_t item_with_gaps(input logic [63:0] gx,
                                                 input logic [63:0] gy,
                                                 input logic [63:0] gz);
        pxs_item_t it;
        place_axis(gx, it.ref_x, it.cur_x);
        place_axis(gy, it.ref_y, it.cur_y);
        place_axis(gz, it.ref_z, it.cur_z);
        return it;
    endfunction

    // Points at opposite corners of the coordinate space: the distance saturates.
    function automatic pxs_item_t opposite_corners(input logic flip);
        pxs_item_t it;
        logic [COORD_W-1:0] p;
        logic [COORD_W-1:0] q;
        p = flip ? 32'h8000_0000 : 32'h7FFF_FFFF;
        q = ~p;
        it = {p, p, p, q, q, q};
        return it;
    endfunction

    function automatic pxs_item_t random_item();
        pxs_item_t   it;
        logic [63:0] big;
        logic [63:0] target;
        logic [63:0] g [3];
        int          pick;
        big  = (range_lo > range_hi) ? {32'd0, range_lo} : {32'd0, range_hi};
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return it;
        end
        if (pick < 35)
        begin
            case ($urandom_range(5))
                0: target = range_lo;
                1: target = range_hi;
                2: target = range_lo + 64'd1;
                3: target = range_hi + 64'd1;
                4: target = range_lo - 64'd1;
                default: target = range_hi - 64'd1;
            endcase
        end
        else
        begin
            target = {$urandom, $urandom} % (big + (big >> 2) + 64'd5);
        end
        g[0] = '0;
        g[1] = '0;
        g[2] = '0;
        if (pick < 70)
        begin
            g[$urandom_range(2)] = target;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                g[i] = {$urandom, $urandom} % ((target * 6) / 10 + 64'd1);
        end
        return item_with_gaps(g[0], g[1], g[2]);
    endfunction

    task automatic send_item(input pxs_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Holds the sender back until every expected result has come.
    task automatic wait_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [DIST_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_MIN_DISTANCE: range_lo = data;
            CFG_MAX_DISTANCE: range_hi = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_range(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi);
        wait_idle();
        write_reg(CFG_MIN_DISTANCE, lo);
        write_reg(CFG_MAX_DISTANCE, hi);
    endtask

    task automatic run_directed();
        // Reset range: full proximity at zero, none at a distance of one.
        send_item(item_with_gaps(64'd0, 64'd0, 64'd0));
        send_item(item_with_gaps(64'd0, 64'd0, 64'd0));
        send_item(item_with_gaps(64'd32768, 64'd0, 64'd0));
        // Just inside the far end: t is tiny and proximity rounds to zero.
        send_item(item_with_gaps(64'd65535, 64'd0, 64'd0));
        send_item(item_with_gaps(64'd1, 64'd0, 64'd0));
        send_item(item_with_gaps(64'd65536, 64'd0, 64'd0));
        send_item(item_with_gaps(64'd12288, 64'd16384, 64'd0));
        send_item(item_with_gaps(64'd0, 64'd0, 64'hFFFF_FFFF));
        send_item(opposite_corners(1'b0));
        send_item(opposite_corners(1'b1));
        wait_idle();
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        send_item(item_with_gaps(64'd32768, 64'd0, 64'd0));
        // Zero-width range: a hard step at the shared distance.
        set_range(32'h0001_0000, 32'h0001_0000);
        send_item(item_with_gaps(64'h1_0000, 64'd0, 64'd0));
        send_item(item_with_gaps(64'h1_0001, 64'd0, 64'd0));
        // Inverted range.
        set_range(32'h0002_0000, 32'h0001_0000);
        send_item(item_with_gaps(64'h1_8000, 64'd0, 64'd0));
        send_item(item_with_gaps(64'h2_0000, 64'd0, 64'd0));
        send_item(item_with_gaps(64'h1_0000, 64'd0, 64'd0));
        set_range(32'h0000_0000, 32'hFFFF_FFFF);
        send_item(item_with_gaps(64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF));
        send_item(opposite_corners(1'b0));
        set_range(32'hFFFF_FFFF, 32'h0000_0000);
        send_item(item_with_gaps(64'd0, 64'd0, 64'd0));
        send_item(opposite_corners(1'b1));
        set_range(32'h0000_0000, 32'h0000_0000);
        send_item(item_with_gaps(64'd0, 64'd0, 64'd0));
        send_item(item_with_gaps(64'd0, 64'd1, 64'd0));
        set_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(item_with_gaps(64'd0, 64'd0, 64'hFFFF_FFFF));
        send_item(opposite_corners(1'b0));
    endtask

    task automatic configure_phase(input int ph);
        logic [DIST_W-1:0] a;
        logic [DIST_W-1:0] b;
        a = $urandom;
        b = $urandom;
        case (ph)
            0: set_range(MIN_DISTANCE_RST, MAX_DISTANCE_RST);
            1: set_range(32'h0000_8000, 32'h0001_8000);
            2: set_range((a < b) ? a : b, (a < b) ? b : a);
            3: set_range((a < b) ? b : a, (a < b) ? a : b);
            4: set_range(a, a);
            5: set_range(32'h0000_0000, 32'hFFFF_FFFF);
            6: set_range(32'hFFFF_FFFF, 32'h0000_0000);
            7:
            begin
                a = $urandom_range(32'h4_0000);
                set_range(a, a + $urandom_range(32'h4_0000, 1));
            end
            default:
            begin
                a = $urandom_range(32'h4_0000);
                set_range(a + $urandom_range(32'h4_0000, 1), a);
            end
        endcase
    endtask

    initial
    begin : stimulus
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_MIN_DISTANCE;
        cfg_data   = '0;
        range_lo   = MIN_DISTANCE_RST;
        range_hi   = MAX_DISTANCE_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            configure_phase(ph);
            @(posedge clk);
            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    // Long hold-off on the result side while items keep coming.
                    hold_requests++;
                end
                1:
                begin
                    idle_pct  = 58;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 58;
                end
                default:
                begin
                    idle_pct  = 13;
                    stall_pct = 13;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
design/pxs_pkg.sv
design/pxs_mul.sv
design/pxs_isqrt.sv
design/pxs_divu.sv
design/proximity_smoothstep.sv
design/pxs_checker.sv
dv/pxs_checker.sv
dv/tb.sv
